>>> sv/srmix_pkg.sv
// Shared types and constants for the stream ring audio mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srmix_pkg;

    localparam int MAX_STREAMS_DEF     = 8;
    localparam int FRAMES_PER_RING_DEF = 256;

    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_QUEUE   = 2'd2;
    localparam logic [1:0] MODE_MIX     = 2'd3;

    localparam logic REG_VOLUME = 1'b0;
    localparam logic REG_MUTE   = 1'b1;

    localparam logic [31:0] REQ_RATE     = 32'd48000;
    localparam logic [7:0]  REQ_CHANNELS = 8'd2;
    localparam logic [7:0]  REQ_BITS     = 8'd16;
    localparam logic [6:0]  VOLUME_MAX   = 7'd100;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        stream_id;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [31:0]        sample_rate;
        logic [7:0]         channel_count;
        logic [7:0]         sample_bits;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [31:0]        new_id;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               underrun;
        logic [31:0]        underrun_count;
        logic [31:0]        frames_mixed;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item
        logic clr_acc;    // clear walk index, match flags and sums
        logic visit;      // handle slot at walk index
        logic rd_issue;   // memory read issued this cycle (mix)
        logic acc;        // accumulate registered read data
        logic commit;     // apply table update
        logic scale;      // multiply sums by volume
        logic finish;     // form result
    } ctl_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic [1:0] mode;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/srmix_ctrl.sv
// Controller state machine for the mixer: sequences slot walk and result.
// Depends on srmix_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmix_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  srmix_pkg::dp_stat_t   stat,
    output srmix_pkg::ctl_cmd_t   cmd,
    output logic                  done
);
    import srmix_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       acc_reg;
    logic       done_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.acc = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    cmd.load = 1'b1;
                    cmd.clr_acc = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.visit = 1'b1;
                cmd.rd_issue = (stat.mode == MODE_MIX);
                if (stat.last_slot)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last read data lands here
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // accumulate the read registered in the cycle after each issue;
    // result strobe registered together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= cmd.rd_issue;
            done_reg <= cmd.finish;
        end
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE) || done_reg;
    end

    assign done = done_reg;
endmodule
`default_nettype wire

>>> sv/srmix_dp.sv
// Datapath for the mixer: slot table, ring store, sums, scaling, counters.
// Depends on srmix_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmix_dp #(
    parameter int MAX_STREAMS     = srmix_pkg::MAX_STREAMS_DEF,
    parameter int FRAMES_PER_RING = srmix_pkg::FRAMES_PER_RING_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  srmix_pkg::in_item_t   item,
    input  srmix_pkg::ctl_cmd_t   cmd,
    output srmix_pkg::dp_stat_t   stat,
    input  wire                   cfg_we,
    input  wire                   cfg_idx,
    input  wire [31:0]            cfg_val,
    output srmix_pkg::out_item_t  res
);
    import srmix_pkg::*;

    localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int PW = $clog2(FRAMES_PER_RING);
    localparam int CW = PW + 1;
    localparam int AW = SW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int SUMW = 16 + SW + 1;
    localparam int PRODW = SUMW + 8;
    // ceil(2^35 / 100): exact floor division for magnitudes below 2^30
    localparam int RECIP_SHIFT = 35;
    localparam logic [28:0] RECIP_100 = 29'd343597384;

    // Slot table
    logic [MAX_STREAMS-1:0] active_reg;
    logic [31:0]  id_reg   [MAX_STREAMS];
    logic [PW-1:0] wp_reg  [MAX_STREAMS];
    logic [PW-1:0] rp_reg  [MAX_STREAMS];
    logic [CW-1:0] cnt_reg [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] pop_reg;

    logic [31:0] next_id_reg, und_total_reg, mix_total_reg;
    logic [6:0]  volume_reg;
    logic        mute_reg;

    in_item_t item_reg;
    logic [SW-1:0] idx_reg;
    logic          found_reg, free_found_reg, any_reg;
    logic [SW-1:0] hit_reg, free_reg;
    logic signed [SUMW-1:0] lsum_reg, rsum_reg;
    logic signed [PRODW-1:0] lprod_reg, rprod_reg;
    logic [31:0] mem_q_reg;
    logic        qfull_reg;
    out_item_t   res_next;

    logic [31:0] mem [DEPTH];

    // Ring pointer advance with wrap at the ring size
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(FRAMES_PER_RING - 1)) ? '0 : p + 1'b1;
    endfunction

    logic fmt_ok;
    assign fmt_ok = (item_reg.sample_rate == REQ_RATE) &&
                    (item_reg.channel_count == REQ_CHANNELS) &&
                    (item_reg.sample_bits == REQ_BITS);

    assign stat.last_slot = (idx_reg == SW'(MAX_STREAMS - 1));
    assign stat.mode = item_reg.mode;

    logic pop_now;
    assign pop_now = active_reg[idx_reg] && (cnt_reg[idx_reg] != '0);

    logic q_ok;
    assign q_ok = found_reg && (cnt_reg[hit_reg] != CW'(FRAMES_PER_RING));

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && item_reg.mode == MODE_QUEUE && q_ok)
            mem[{hit_reg, wp_reg[hit_reg]}] <= {item_reg.right_in, item_reg.left_in};
        if (cmd.rd_issue)
            mem_q_reg <= mem[{idx_reg, rp_reg[idx_reg]}];
    end

    // Item capture, walk, search, accumulate and scale
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.clr_acc)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg <= 1'b0;
            hit_reg <= '0;
            free_reg <= '0;
            lsum_reg <= '0;
            rsum_reg <= '0;
            pop_reg <= '0;
        end
        if (cmd.visit)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!found_reg && active_reg[idx_reg] && id_reg[idx_reg] == item_reg.stream_id)
            begin
                found_reg <= 1'b1;
                hit_reg <= idx_reg;
            end
            if (!free_found_reg && !active_reg[idx_reg])
            begin
                free_found_reg <= 1'b1;
                free_reg <= idx_reg;
            end
            pop_reg[idx_reg] <= pop_now;
            if (pop_now)
                any_reg <= 1'b1;
        end
        if (cmd.acc && pop_reg[SW'(idx_reg - 1'b1)])
        begin
            lsum_reg <= lsum_reg + SUMW'(signed'(mem_q_reg[15:0]));
            rsum_reg <= rsum_reg + SUMW'(signed'(mem_q_reg[31:16]));
        end
        if (cmd.scale)
        begin
            if (mute_reg)
            begin
                lprod_reg <= '0;
                rprod_reg <= '0;
            end
            else
            begin
                lprod_reg <= lsum_reg * signed'({1'b0, volume_reg});
                rprod_reg <= rsum_reg * signed'({1'b0, volume_reg});
            end
        end
    end

    // Table update and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                id_reg[i] <= '0;
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            next_id_reg <= 32'd1;
            und_total_reg <= '0;
            mix_total_reg <= '0;
            volume_reg <= VOLUME_MAX;
            mute_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_VOLUME)
                    volume_reg <= (cfg_val > 32'(VOLUME_MAX)) ? VOLUME_MAX : cfg_val[6:0];
                else
                    mute_reg <= cfg_val[0];
            end
            if (cmd.commit)
            begin
                case (item_reg.mode)
                    MODE_CREATE:
                    begin
                        if (fmt_ok && free_found_reg)
                        begin
                            active_reg[free_reg] <= 1'b1;
                            id_reg[free_reg] <= next_id_reg;
                            wp_reg[free_reg] <= '0;
                            rp_reg[free_reg] <= '0;
                            cnt_reg[free_reg] <= '0;
                            next_id_reg <= (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                           : next_id_reg + 32'd1;
                        end
                    end
                    MODE_DESTROY:
                    begin
                        if (found_reg)
                        begin
                            active_reg[hit_reg] <= 1'b0;
                            id_reg[hit_reg] <= '0;
                            wp_reg[hit_reg] <= '0;
                            rp_reg[hit_reg] <= '0;
                            cnt_reg[hit_reg] <= '0;
                        end
                    end
                    MODE_QUEUE:
                    begin
                        if (q_ok)
                        begin
                            wp_reg[hit_reg] <= ptr_inc(wp_reg[hit_reg]);
                            cnt_reg[hit_reg] <= cnt_reg[hit_reg] + 1'b1;
                        end
                    end
                    MODE_MIX:
                    begin
                        for (int i = 0; i < MAX_STREAMS; i++)
                        begin
                            if (pop_reg[i])
                            begin
                                rp_reg[i] <= ptr_inc(rp_reg[i]);
                                cnt_reg[i] <= cnt_reg[i] - 1'b1;
                            end
                        end
                        if (!any_reg)
                            und_total_reg <= und_total_reg + 32'd1;
                        mix_total_reg <= mix_total_reg + 32'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // queue status: ring-full captured before commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            qfull_reg <= found_reg && !q_ok;
    end

    // Divide by 100 truncating toward zero (reciprocal multiply), then saturate
    function automatic logic signed [15:0] div_sat(input logic signed [PRODW-1:0] p);
        logic [PRODW-1:0] mag;
        logic [PRODW+28:0] q;
        logic [PRODW-1:0] qt;
        logic signed [PRODW:0] s;
        mag = p[PRODW-1] ? PRODW'(-p) : PRODW'(p);
        q = (PRODW+29)'(mag) * (PRODW+29)'(RECIP_100);
        qt = PRODW'(q >> RECIP_SHIFT);
        s = p[PRODW-1] ? -signed'({1'b0, qt}) : signed'({1'b0, qt});
        if (s > 32767)
            div_sat = 16'sd32767;
        else if (s < -32768)
            div_sat = -16'sd32768;
        else
            div_sat = s[15:0];
    endfunction

    // Result value
    always_comb
    begin
        res_next = '0;
        res_next.underrun_count = und_total_reg;
        res_next.frames_mixed = mix_total_reg;
        case (item_reg.mode)
            MODE_CREATE:
            begin
                res_next.status = !(fmt_ok && free_found_reg);
                if (fmt_ok && free_found_reg)
                    res_next.new_id = id_reg[free_reg];
            end
            MODE_DESTROY:
                res_next.status = !found_reg;
            MODE_QUEUE:
                res_next.status = !found_reg || qfull_reg;
            MODE_MIX:
            begin
                res_next.left_out = div_sat(lprod_reg);
                res_next.right_out = div_sat(rprod_reg);
                res_next.underrun = !any_reg;
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            res <= res_next;
    end
endmodule
`default_nettype wire

>>> sv/stream_ring_audio_mixer_unit.sv
// Top level of the stream ring audio mixer: controller plus datapath.
// Depends on srmix_pkg, srmix_ctrl, srmix_dp.
`timescale 1ns / 1ps
`default_nettype none
// Every command walks the slot table one slot per cycle, reading the ring
// store through its single read port for a mix, then drains, commits, scales
// and registers the result. A new command is taken only once busy is low
// again, not while the last one is in flight. The result appears on result
// for one cycle with done high and cannot be stalled; busy stays high until
// that cycle ends. Configuration writes are always ready but are to be made
// only while busy is low.
module stream_ring_audio_mixer_unit #(
    parameter int MAX_STREAMS     = srmix_pkg::MAX_STREAMS_DEF,
    parameter int FRAMES_PER_RING = srmix_pkg::FRAMES_PER_RING_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  srmix_pkg::in_item_t  cmd_in,
    output logic                 done,
    output srmix_pkg::out_item_t result,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_index,
    input  wire [31:0]           cfg_data
);
    import srmix_pkg::*;

    ctl_cmd_t  cmd;
    dp_stat_t  stat;
    out_item_t res_raw;

    srmix_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd),
        .done  (done)
    );

    srmix_dp #(
        .MAX_STREAMS     (MAX_STREAMS),
        .FRAMES_PER_RING (FRAMES_PER_RING)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (cmd_in),
        .cmd     (cmd),
        .stat    (stat),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_idx (cfg_index),
        .cfg_val (cfg_data),
        .res     (res_raw)
    );

    assign cfg_ready = 1'b1;
    assign result    = res_raw;
endmodule
`default_nettype wire

>>> tb/stream_ring_audio_mixer_unit_test.sv
// Self-checking testbench for stream_ring_audio_mixer_unit: a predictor of the
// stream table and mixer checks every result strobe. Depends on srmix_pkg and the RTL.
`timescale 1ns / 1ps
module stream_ring_audio_mixer_unit_test;
    import srmix_pkg::*;

    localparam int SLOTS       = 8;
    localparam int RING_FRAMES = 256;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  cmd_in = '0;
    logic      done;
    out_item_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    stream_ring_audio_mixer_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mixer state as predicted
    logic               slot_on [SLOTS];
    logic [31:0]        slot_ident [SLOTS];
    int                 wr_ptr [SLOTS];
    int                 rd_ptr [SLOTS];
    int                 fill [SLOTS];
    logic signed [15:0] ring_left [SLOTS][RING_FRAMES];
    logic signed [15:0] ring_right [SLOTS][RING_FRAMES];
    logic [31:0]        next_ident;
    logic [31:0]        underrun_tally;
    logic [31:0]        mixed_tally;
    logic [6:0]         volume;
    logic               muted;

    out_item_t expected_results[$];
    int        mismatches = 0;
    int        idle_cycles = 0;

    function automatic int find_stream(input logic [31:0] ident);
        for (int i = 0; i < SLOTS; i++)
            if (slot_on[i] && slot_ident[i] == ident) return i;
        return -1;
    endfunction

    function automatic void clear_stream(input int i);
        slot_on[i] = 1'b0;
        slot_ident[i] = '0;
        wr_ptr[i] = 0;
        rd_ptr[i] = 0;
        fill[i] = 0;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Predicts the result of one command and advances the state
    function automatic out_item_t mixer_predict(input in_item_t c);
        out_item_t r;
        int        s;
        longint    lsum;
        longint    rsum;
        bit        any;
        r = '0;
        case (c.mode)
            MODE_CREATE:
            begin
                r.status = 1'b1;
                if (c.sample_rate == REQ_RATE && c.channel_count == REQ_CHANNELS &&
                    c.sample_bits == REQ_BITS)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_on[i])
                        begin
                            clear_stream(i);
                            slot_on[i] = 1'b1;
                            slot_ident[i] = next_ident;
                            r.new_id = next_ident;
                            next_ident++;
                            if (next_ident == 0) next_ident = 1;
                            r.status = 1'b0;
                            break;
                        end
                    end
                end
            end
            MODE_DESTROY:
            begin
                s = find_stream(c.stream_id);
                if (s < 0) r.status = 1'b1;
                else clear_stream(s);
            end
            MODE_QUEUE:
            begin
                s = find_stream(c.stream_id);
                if (s < 0 || fill[s] >= RING_FRAMES) r.status = 1'b1;
                else
                begin
                    ring_left[s][wr_ptr[s]] = c.left_in;
                    ring_right[s][wr_ptr[s]] = c.right_in;
                    wr_ptr[s] = (wr_ptr[s] + 1) % RING_FRAMES;
                    fill[s]++;
                end
            end
            default:
            begin
                lsum = 0;
                rsum = 0;
                any = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[i] && fill[i] != 0)
                    begin
                        lsum += ring_left[i][rd_ptr[i]];
                        rsum += ring_right[i][rd_ptr[i]];
                        rd_ptr[i] = (rd_ptr[i] + 1) % RING_FRAMES;
                        fill[i]--;
                        any = 1'b1;
                    end
                end
                if (!any)
                begin
                    underrun_tally++;
                    r.underrun = 1'b1;
                end
                if (muted)
                begin
                    lsum = 0;
                    rsum = 0;
                end
                else
                begin
                    lsum = (lsum * longint'(volume)) / 100;
                    rsum = (rsum * longint'(volume)) / 100;
                end
                r.left_out = clamp16(lsum);
                r.right_out = clamp16(rsum);
                mixed_tally++;
            end
        endcase
        r.underrun_count = underrun_tally;
        r.frames_mixed = mixed_tally;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Result checker: every strobe is a transfer
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'h0, 32'h0);
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.new_id !== want.new_id)
                    report_mismatch("new_id", result.new_id, want.new_id);
                if (result.left_out !== want.left_out)
                    report_mismatch("left_out", 32'(result.left_out), 32'(want.left_out));
                if (result.right_out !== want.right_out)
                    report_mismatch("right_out", 32'(result.right_out),
                                    32'(want.right_out));
                if (result.underrun !== want.underrun)
                    report_mismatch("underrun", 32'(result.underrun), 32'(want.underrun));
                if (result.underrun_count !== want.underrun_count)
                    report_mismatch("underrun_count", result.underrun_count,
                                    want.underrun_count);
                if (result.frames_mixed !== want.frames_mixed)
                    report_mismatch("frames_mixed", result.frames_mixed, want.frames_mixed);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stream_ring_audio_mixer_unit_test failed");
            $finish;
        end
    end

    // One command transfer, with a random lead-in gap
    task automatic send_cmd(input in_item_t c);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd_in <= c;
        do @(posedge clk); while (busy);
        expected_results.push_back(mixer_predict(c));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_VOLUME) volume = (data > 100) ? VOLUME_MAX : data[6:0];
        else muted = data[0];
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_cmd(input logic [1:0] m);
        in_item_t c;
        c.mode = m;
        c.stream_id = $urandom;
        c.left_in = 16'($urandom);
        c.right_in = 16'($urandom);
        c.sample_rate = $urandom;
        c.channel_count = 8'($urandom);
        c.sample_bits = 8'($urandom);
        return c;
    endfunction

    function automatic in_item_t make_create();
        in_item_t c;
        c = random_cmd(MODE_CREATE);
        c.sample_rate = REQ_RATE;
        c.channel_count = REQ_CHANNELS;
        c.sample_bits = REQ_BITS;
        return c;
    endfunction

    // Mostly a live id, sometimes zero, a random one or the next id to be given
    function automatic logic [31:0] pick_ident();
        int live[$];
        int pick;
        for (int i = 0; i < SLOTS; i++) if (slot_on[i]) live.push_back(i);
        pick = $urandom_range(0, 19);
        if (pick == 0) return 32'h0;
        if (pick == 1 || live.size() == 0) return $urandom;
        if (pick == 2) return next_ident;
        return slot_ident[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function automatic in_item_t make_queue(input logic [31:0] ident,
                                            input logic signed [15:0] l,
                                            input logic signed [15:0] r);
        in_item_t c;
        c = random_cmd(MODE_QUEUE);
        c.stream_id = ident;
        c.left_in = l;
        c.right_in = r;
        return c;
    endfunction

    task automatic test_directed();
        in_item_t c;
        // bad formats, one field off each
        c = make_create(); c.sample_rate = 32'd44100;   send_cmd(c);
        c = make_create(); c.channel_count = 8'd1;      send_cmd(c);
        c = make_create(); c.sample_bits = 8'd8;        send_cmd(c);
        // mix with nothing queued is an underrun
        send_cmd(random_cmd(MODE_MIX));
        // fill every slot, then one more with no slot left
        for (int i = 0; i <= SLOTS; i++) send_cmd(make_create());
        // id zero and unknown id
        send_cmd(make_queue(32'h0, 16'sd1, 16'sd1));
        send_cmd(make_queue(32'hFFFF_FFFF, 16'sd1, 16'sd1));
        // extremes summed across streams: the right sum saturates low, the left does not
        send_cmd(make_queue(32'd1, 16'sh7FFF, -16'sh8000));
        send_cmd(make_queue(32'd2, 16'sh7FFF, -16'sh8000));
        send_cmd(make_queue(32'd3, -16'sh8000, 16'sh7FFF));
        send_cmd(random_cmd(MODE_MIX));
        send_cmd(random_cmd(MODE_MIX));
        // destroy, then destroy the same id again
        c = random_cmd(MODE_DESTROY); c.stream_id = 32'd2; send_cmd(c);
        send_cmd(c);
        // a recreated stream reuses the lowest free slot
        send_cmd(make_create());
        c = random_cmd(MODE_DESTROY); c.stream_id = 32'h0; send_cmd(c);
    endtask

    // Ring full rejects the frame; drain afterwards
    task automatic test_ring_full();
        logic [31:0] ident;
        ident = pick_ident();
        if (find_stream(ident) < 0) ident = slot_ident[0];
        for (int i = 0; i <= RING_FRAMES; i++)
            send_cmd(make_queue(ident, 16'($urandom), 16'($urandom)));
        for (int i = 0; i <= RING_FRAMES; i++) send_cmd(random_cmd(MODE_MIX));
    endtask

    task automatic random_burst(input int count);
        int pick;
        in_item_t c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                c = ($urandom_range(0, 3) == 0) ? random_cmd(MODE_CREATE) : make_create();
            end
            else if (pick < 16)
            begin
                c = random_cmd(MODE_DESTROY);
                c.stream_id = pick_ident();
            end
            else if (pick < 62)
            begin
                c = random_cmd(MODE_QUEUE);
                c.stream_id = pick_ident();
            end
            else
                c = random_cmd(MODE_MIX);
            send_cmd(c);
        end
    endtask

    // Several gain settings, extremes among them, with random traffic
    task automatic test_settings_and_random();
        write_reg(REG_VOLUME, 32'd0);
        random_burst(150);
        write_reg(REG_VOLUME, 32'hFFFF_FFFF);
        random_burst(200);
        write_reg(REG_VOLUME, 32'd37);
        random_burst(200);
        write_reg(REG_MUTE, 32'd1);
        random_burst(100);
        write_reg(REG_MUTE, 32'hFFFF_FFFE);
        write_reg(REG_VOLUME, 32'd101);
        random_burst(100);
        write_reg(REG_VOLUME, $urandom_range(1, 99));
        random_burst(100);
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++) clear_stream(i);
        next_ident = 32'd1;
        underrun_tally = '0;
        mixed_tally = '0;
        volume = VOLUME_MAX;
        muted = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_ring_full();
        test_settings_and_random();
        wait_idle();
        if (mismatches == 0)
            $display("stream_ring_audio_mixer_unit_test passed");
        else
            $display("stream_ring_audio_mixer_unit_test failed");
        $finish;
    end
endmodule
